// ===== src/sli_pkg.sv =====
// Shared types and constants for the sorted list block.
// Used by the channel interfaces, the list cell and the top level.
package sli_pkg;

   localparam int DATA_W           = 32;
   localparam int ENTRY_COUNT_W    = 5;
   localparam int DEFAULT_CAPACITY = 16;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic shift_ins;
      logic shift_rem;
   } cell_ctrl_type;

   typedef struct packed {
      logic lt;
      logic first_eq;
   } cell_status_type;

endpackage

// ===== src/sli_req_if.sv =====
// Request channel: valid/ready handshake carrying one request item.
// Depends on sli_pkg for the data width.
interface sli_req_if import sli_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink (input valid, input req_type, input value, output ready);
endinterface

// ===== src/sli_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result item.
// Depends on sli_pkg for the field widths.
interface sli_rsp_if import sli_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [ENTRY_COUNT_W-1:0]  entry_count;
   logic signed [DATA_W-1:0]  smallest_value;

   modport source (output valid, output status, output entry_count,
                   output smallest_value, input ready);
   modport sink (input valid, input status, input entry_count,
                 input smallest_value, output ready);
endinterface

// ===== src/sli_cell.sv =====
// One position of the sorted list: holds an entry, compares it with the request value
// and shifts in from its left or right neighbor. Depends on sli_pkg.
module sli_cell import sli_pkg::*; (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] value,
   input  logic                     occupied,
   input  logic                     left_lt,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   output cell_status_type          status,
   output logic signed [DATA_W-1:0] entry,
   output logic signed [DATA_W-1:0] entry_next
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   assign status.lt       = occupied && (entry_ff < value);
   assign status.first_eq = occupied && (entry_ff == value) && left_lt;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_ins && !status.lt) begin
         entry_in = left_lt ? value : left_entry;
      end else if (ctrl.shift_rem && !status.lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// ===== src/sorted_list_insert_delete.sv =====
// Sorted list of signed values kept in a chain of compare-and-shift cells.
// Accepted requests register their result item directly in the output register; all cells
// compare and shift in the same cycle. One request per cycle unless a result waits unread.
// Reset: synchronous, clears the entry count and the output valid; entries are not cleared.
// Depends on sli_pkg, sli_req_if, sli_rsp_if and sli_cell.
module sorted_list_insert_delete import sli_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input logic          clock,
   input logic          reset,
   sli_req_if.sink      req_ch,
   sli_rsp_if.source    rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   logic [ENTRY_COUNT_W-1:0] entry_count_ff;
   logic signed [DATA_W-1:0] smallest_ff;
   logic signed [DATA_W-1:0] smallest_in;

   logic                     accept;
   logic                     is_insert;
   logic                     full;
   logic                     found;
   cell_ctrl_type            ctrl;
   cell_status_type          cst [CAPACITY];
   logic [CAPACITY-1:0]      first_eq;
   logic signed [DATA_W-1:0] entry [CAPACITY];
   logic signed [DATA_W-1:0] entry_next [CAPACITY];
   logic [CW+ENTRY_COUNT_W-1:0] count_ext;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_insert    = (req_kind_type'(req_ch.req_type) == REQ_INSERT);
   assign full         = (count_ff == CW'(CAPACITY));
   assign found        = |first_eq;

   assign ctrl.shift_ins = accept && is_insert && !full;
   assign ctrl.shift_rem = accept && !is_insert && found;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     left_lt;
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = req_ch.value;
      end else begin : g_mid
         assign left_lt    = cst[i-1].lt;
         assign left_entry = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      sli_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .value       (req_ch.value),
         .occupied    (CW'(i) < count_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .status      (cst[i]),
         .entry       (entry[i]),
         .entry_next  (entry_next[i])
      );

      assign first_eq[i] = cst[i].first_eq;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.shift_rem) begin
         count_in = count_ff - CW'(1);
      end

      if (is_insert) begin
         status_in = full ? ST_FULL : ST_DONE;
      end else begin
         status_in = found ? ST_DONE : ST_NOT_FOUND;
      end

      smallest_in = (count_in != '0) ? entry_next[0] : '0;

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         entry_count_ff <= count_ext[ENTRY_COUNT_W-1:0];
         smallest_ff    <= smallest_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.entry_count    = entry_count_ff;
   assign rsp_ch.smallest_value = smallest_ff;

endmodule
